### sv/u8sv_pkg.sv
// ----------------------------------------------------------------------------
// u8sv_pkg
// Types and constants used by the UTF-8 stream validator: sequence lengths,
// remaining counts and the smallest code point allowed for each multi-byte length.
// ----------------------------------------------------------------------------
package u8sv_pkg;

    localparam int CP_W  = 21;
    localparam int REM_W = 2;
    localparam int LEN_W = 3;

    typedef logic [CP_W-1:0]  t_cp;
    typedef logic [REM_W-1:0] t_rem;
    typedef logic [LEN_W-1:0] t_len;

    localparam t_len LEN_NONE = 3'd0;
    localparam t_len LEN_2    = 3'd2;
    localparam t_len LEN_3    = 3'd3;
    localparam t_len LEN_4    = 3'd4;

    localparam t_rem REM_NONE = 2'd0;
    localparam t_rem REM_1    = 2'd1;
    localparam t_rem REM_2    = 2'd2;
    localparam t_rem REM_3    = 2'd3;

    localparam t_cp LEAST_2 = 21'h00080;
    localparam t_cp LEAST_3 = 21'h00800;
    localparam t_cp LEAST_4 = 21'h10000;

endpackage

### sv/utf8_stream_validator.sv
// ----------------------------------------------------------------------------
// utf8_stream_validator
// Checks a byte stream, one buffer at a time, for valid UTF-8.
// ----------------------------------------------------------------------------
// Input channel: i_valid / o_stall carry one byte (i_data_byte) per transfer,
// with i_end_of_buffer marking the last byte of a buffer. Empty buffers are
// never sent.
// Output channel: o_valid / i_stall carry one transfer per buffer,
// o_buffer_valid = 1 if the whole buffer was valid UTF-8.
// A transferred byte is held in the input register and decoded when it leaves
// it; a last byte's result is registered in the output register at that point.
// Throughput: one byte per cycle unless a held result stalls a last byte; each
// byte updates remaining count, length, partial code point and error flag.
// Reset clears the decode state and both valid flags; no result is lost or
// replayed. While i_stall holds a result, a further last byte waits in the
// input register and o_stall rises; bytes that are not last keep flowing.
// Errors: stray continuation, lead F8..FF, missing continuation, sequence
// cut short at buffer end, overlong forms. Surrogates and F5..F7 pass.
// ----------------------------------------------------------------------------
module utf8_stream_validator (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_stall,
    input  logic [7:0] i_data_byte,
    input  logic       i_end_of_buffer,
    output logic       o_valid,
    input  logic       i_stall,
    output logic       o_buffer_valid
);
    import u8sv_pkg::*;

    logic       r_in_valid;
    logic [7:0] r_in_byte;
    logic       r_in_eob;
    logic       r_out_valid;
    logic       r_out_bv;

    t_rem r_rem, n_rem;
    t_len r_len, n_len;
    t_cp  r_cp,  n_cp;
    logic r_err, n_err;

    t_cp  cp_shift;
    t_cp  least;
    t_rem rem_dec;
    logic advance;
    logic in_take;
    logic out_take;
    logic n_bv;

    assign out_take = r_out_valid && !i_stall;
    assign advance  = r_in_valid && (!r_in_eob || !r_out_valid || !i_stall);
    assign o_stall  = r_in_valid && !advance;
    assign in_take  = i_valid && !o_stall;

    assign cp_shift = {r_cp[CP_W-7:0], r_in_byte[5:0]};
    assign rem_dec  = r_rem - REM_1;

    always_comb begin
        case (r_len)
            LEN_2:   least = LEAST_2;
            LEN_3:   least = LEAST_3;
            default: least = LEAST_4;
        endcase
    end

    always_comb begin
        n_rem = r_rem;
        n_len = r_len;
        n_cp  = r_cp;
        n_err = r_err;
        if (r_rem == REM_NONE) begin
            case (r_in_byte) inside
                [8'h00:8'h7F]: begin
                end
                [8'h80:8'hBF]: begin
                    n_err = 1'b1;
                end
                [8'hC0:8'hDF]: begin
                    n_len = LEN_2;
                    n_rem = REM_1;
                    n_cp  = t_cp'(r_in_byte[4:0]);
                end
                [8'hE0:8'hEF]: begin
                    n_len = LEN_3;
                    n_rem = REM_2;
                    n_cp  = t_cp'(r_in_byte[3:0]);
                end
                [8'hF0:8'hF7]: begin
                    n_len = LEN_4;
                    n_rem = REM_3;
                    n_cp  = t_cp'(r_in_byte[2:0]);
                end
                default: begin
                    n_err = 1'b1;
                end
            endcase
        end else if (r_in_byte[7:6] != 2'b10) begin
            n_err = 1'b1;
            n_rem = REM_NONE;
            n_len = LEN_NONE;
            n_cp  = '0;
        end else begin
            n_rem = rem_dec;
            if (rem_dec == REM_NONE) begin
                if (cp_shift < least) begin
                    n_err = 1'b1;
                end
                n_len = LEN_NONE;
                n_cp  = '0;
            end else begin
                n_cp = cp_shift;
            end
        end
        n_bv = !(n_err || (n_rem != REM_NONE));
        if (r_in_eob) begin
            n_rem = REM_NONE;
            n_len = LEN_NONE;
            n_cp  = '0;
            n_err = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_rem       <= REM_NONE;
            r_len       <= LEN_NONE;
            r_cp        <= '0;
            r_err       <= 1'b0;
        end else begin
            if (in_take) begin
                r_in_valid <= 1'b1;
            end else if (advance) begin
                r_in_valid <= 1'b0;
            end
            if (advance && r_in_eob) begin
                r_out_valid <= 1'b1;
            end else if (out_take) begin
                r_out_valid <= 1'b0;
            end
            if (advance) begin
                r_rem <= n_rem;
                r_len <= n_len;
                r_cp  <= n_cp;
                r_err <= n_err;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_in_byte <= i_data_byte;
            r_in_eob  <= i_end_of_buffer;
        end
        if (advance && r_in_eob) begin
            r_out_bv <= n_bv;
        end
    end

    assign o_valid        = r_out_valid;
    assign o_buffer_valid = r_out_bv;

`ifndef SYNTHESIS
    a_clear_after_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        advance && r_in_eob |=> (r_rem == REM_NONE) && (r_len == LEN_NONE)
            && (r_cp == '0) && !r_err)
        else $error("decode state not cleared after last byte");

    a_len_tracks_rem: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_rem == REM_NONE) == (r_len == LEN_NONE))
        else $error("sequence length and remaining count disagree");

    a_stall_only_on_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> r_in_valid && r_in_eob && r_out_valid && i_stall)
        else $error("input stalled without a pending result");
`endif

endmodule
